[hw/rtl/cxa_pkg.sv]
// Shared widths, operation codes and saturation helper for the complex accumulator.
`timescale 1ns / 1ps
`default_nettype none

package cxa_pkg;

   // Part width and fraction bits of the Q format
   localparam int DW  = 32;
   localparam int FW  = 16;
   // Product, signed sum of two products and divider numerator widths
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 1;
   localparam int NW  = PW + FW;
   // Step counter widths of the serial units
   localparam int MCW = $clog2(DW);
   localparam int DCW = $clog2(NW);

   typedef enum logic [2:0] {
      OP_LOAD = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef struct packed {
      logic          ovf;
      logic [DW-1:0] val;
   } sat_type;

   // Clamp a sign and magnitude pair to the signed part range
   function automatic sat_type sat_mag(input logic neg, input logic [NW-1:0] mag);
      sat_type       r;
      logic [NW-1:0] lim;
      lim = {{(NW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
      if (!neg) begin
         lim = lim - NW'(1);
      end
      if (mag > lim) begin
         r.ovf = 1'b1;
         r.val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         r.ovf = 1'b0;
         r.val = neg ? (~mag[DW-1:0] + DW'(1)) : mag[DW-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/cxa_mul.sv]
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
`timescale 1ns / 1ps
`default_nettype none

module cxa_mul (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [cxa_pkg::DW-1:0]   a,
   input  wire logic signed [cxa_pkg::DW-1:0]   b,
   output logic                                 done,
   output logic signed [cxa_pkg::PW-1:0]        product
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [cxa_pkg::MCW-1:0]    cnt_ff;
   logic [cxa_pkg::DW-1:0]     mcand_ff;
   logic [cxa_pkg::PW-1:0]     prod_ff;
   logic                       neg_ff;

   logic [cxa_pkg::DW-1:0]     mag_a;
   logic [cxa_pkg::DW-1:0]     mag_b;
   logic [cxa_pkg::DW:0]       part_sum;
   logic [cxa_pkg::PW-1:0]     prod_in;

   // Take operand magnitudes; sign is applied at the end
   assign mag_a = a[cxa_pkg::DW-1] ? (~a + cxa_pkg::DW'(1)) : a;
   assign mag_b = b[cxa_pkg::DW-1] ? (~b + cxa_pkg::DW'(1)) : b;

   // Add the multiplicand into the high half when the low bit is set, then shift right
   assign part_sum = {1'b0, prod_ff[cxa_pkg::PW-1:cxa_pkg::DW]} +
                     {1'b0, (prod_ff[0] ? mcand_ff : {cxa_pkg::DW{1'b0}})};
   assign prod_in  = {part_sum, prod_ff[cxa_pkg::DW-1:1]};

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cxa_pkg::MCW'(cxa_pkg::DW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - cxa_pkg::MCW'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Hold operands and the partial product
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mag_a;
         prod_ff  <= {{cxa_pkg::DW{1'b0}}, mag_b};
         neg_ff   <= a[cxa_pkg::DW-1] ^ b[cxa_pkg::DW-1];
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done    = done_ff;
   assign product = neg_ff ? (~prod_ff + cxa_pkg::PW'(1)) : prod_ff;

endmodule

`default_nettype wire

[hw/rtl/cxa_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cxa_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [cxa_pkg::NW-1:0]   num,
   input  wire logic [cxa_pkg::PW-1:0]   den,
   output logic                          done,
   output logic [cxa_pkg::NW-1:0]        quo
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [cxa_pkg::DCW-1:0]  cnt_ff;
   logic [cxa_pkg::NW-1:0]   q_ff;
   logic [cxa_pkg::PW-1:0]   rem_ff;
   logic [cxa_pkg::PW-1:0]   den_ff;

   logic [cxa_pkg::PW:0]     rem_shift;
   logic [cxa_pkg::PW:0]     rem_diff;
   logic                     fits;

   // Bring down the next numerator bit and try the subtract
   assign rem_shift = {rem_ff, q_ff[cxa_pkg::NW-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cxa_pkg::DCW'(cxa_pkg::NW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - cxa_pkg::DCW'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift quotient bits in as numerator bits leave
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[cxa_pkg::NW-2:0], fits};
         rem_ff <= fits ? rem_diff[cxa_pkg::PW-1:0] : rem_shift[cxa_pkg::PW-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

`default_nettype wire

[hw/rtl/complex_accumulator_alu.sv]
// Complex accumulator unit: load, add, subtract, multiply and divide in signed Q16.16.
//
// Input beats (req_*) carry an operation and a complex operand; each accepted beat
// yields exactly one result beat (rsp_*) holding the new accumulator and two flags.
// Both channels use valid/ready. One item is in work at a time: req_ready is high
// only while the unit is idle, and a finished result waits in the output register.
// Path from accept to rsp_valid:
//   load, add, subtract, unused codes, zero-divisor divide: the add state, then push
//   multiply: two rounds of two 32-step serial multipliers
//   divide:   three multiplier rounds, then two 80-step
//             serial dividers running side by side
// The serial multipliers work one bit per cycle and the restoring dividers one
// quotient bit per cycle. req_ready rises together with rsp_valid, so the
// next beat can be accepted while the result is still offered.
// A new item is accepted while the previous result still waits; if the receiver
// stalls, the unit holds its next result until the output register frees.
// Reset clears the accumulator to zero and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module complex_accumulator_alu (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [2:0]                     req_op,
   input  wire logic signed [cxa_pkg::DW-1:0]  req_operand_real,
   input  wire logic signed [cxa_pkg::DW-1:0]  req_operand_imag,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [cxa_pkg::DW-1:0]       rsp_result_real,
   output logic signed [cxa_pkg::DW-1:0]       rsp_result_imag,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_overflow
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_MUL,
      S_MAG,
      S_DIV,
      S_FIN,
      S_PUSH
   } state_type;

   state_type                         state_ff;
   logic [2:0]                        op_ff;
   logic [1:0]                        round_ff;
   logic signed [cxa_pkg::DW-1:0]     br_ff;
   logic signed [cxa_pkg::DW-1:0]     bi_ff;
   logic signed [cxa_pkg::DW-1:0]     acc_re_ff;
   logic signed [cxa_pkg::DW-1:0]     acc_im_ff;
   logic signed [cxa_pkg::SW-1:0]     sum_re_ff;
   logic signed [cxa_pkg::SW-1:0]     sum_im_ff;
   logic [cxa_pkg::PW-1:0]            den_ff;
   logic                              neg_re_ff;
   logic                              neg_im_ff;
   logic [cxa_pkg::PW-1:0]            mag_re_ff;
   logic [cxa_pkg::PW-1:0]            mag_im_ff;
   logic [cxa_pkg::DW-1:0]            res_re_ff;
   logic [cxa_pkg::DW-1:0]            res_im_ff;
   logic                              dbz_ff;
   logic                              ovf_ff;
   logic                              rsp_valid_ff;
   logic [cxa_pkg::DW-1:0]            rsp_re_ff;
   logic [cxa_pkg::DW-1:0]            rsp_im_ff;
   logic                              rsp_dbz_ff;
   logic                              rsp_ovf_ff;
   logic                              mul_start_ff;
   logic signed [cxa_pkg::DW-1:0]     ma_a_ff;
   logic signed [cxa_pkg::DW-1:0]     ma_b_ff;
   logic signed [cxa_pkg::DW-1:0]     mb_a_ff;
   logic signed [cxa_pkg::DW-1:0]     mb_b_ff;
   logic                              div_start_ff;

   logic                              mul_done_a;
   logic                              mul_done_b;
   logic signed [cxa_pkg::PW-1:0]     prod_a;
   logic signed [cxa_pkg::PW-1:0]     prod_b;
   logic                              div_done_re;
   logic                              div_done_im;
   logic [cxa_pkg::NW-1:0]            quo_re;
   logic [cxa_pkg::NW-1:0]            quo_im;
   logic signed [cxa_pkg::SW-1:0]     prod_sum;
   logic signed [cxa_pkg::SW-1:0]     prod_diff;
   logic                              out_free;
   cxa_pkg::sat_type                  fin_re;
   cxa_pkg::sat_type                  fin_im;
   cxa_pkg::sat_type                  add_re;
   cxa_pkg::sat_type                  add_im;

   // Add or subtract one part with saturation to the part range
   function automatic cxa_pkg::sat_type sat_add(input logic [cxa_pkg::DW-1:0] a,
                                                input logic [cxa_pkg::DW-1:0] b,
                                                input logic sub);
      cxa_pkg::sat_type       r;
      logic [cxa_pkg::DW:0]   s;
      if (sub) begin
         s = {a[cxa_pkg::DW-1], a} - {b[cxa_pkg::DW-1], b};
      end else begin
         s = {a[cxa_pkg::DW-1], a} + {b[cxa_pkg::DW-1], b};
      end
      if (s[cxa_pkg::DW] != s[cxa_pkg::DW-1]) begin
         r.ovf = 1'b1;
         r.val = s[cxa_pkg::DW] ? {1'b1, {(cxa_pkg::DW-1){1'b0}}}
                                : {1'b0, {(cxa_pkg::DW-1){1'b1}}};
      end else begin
         r.ovf = 1'b0;
         r.val = s[cxa_pkg::DW-1:0];
      end
      return r;
   endfunction

   cxa_mul u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (ma_a_ff),
      .b       (ma_b_ff),
      .done    (mul_done_a),
      .product (prod_a)
   );

   cxa_mul u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mb_a_ff),
      .b       (mb_b_ff),
      .done    (mul_done_b),
      .product (prod_b)
   );

   cxa_div u_div_re (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   ({mag_re_ff, {cxa_pkg::FW{1'b0}}}),
      .den   (den_ff),
      .done  (div_done_re),
      .quo   (quo_re)
   );

   cxa_div u_div_im (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   ({mag_im_ff, {cxa_pkg::FW{1'b0}}}),
      .den   (den_ff),
      .done  (div_done_im),
      .quo   (quo_im)
   );

   // Combine the two products of a round
   assign prod_sum  = {prod_a[cxa_pkg::PW-1], prod_a} + {prod_b[cxa_pkg::PW-1], prod_b};
   assign prod_diff = {prod_a[cxa_pkg::PW-1], prod_a} - {prod_b[cxa_pkg::PW-1], prod_b};

   // Final truncation and saturation: product sums drop fraction bits, quotients are ready
   always_comb begin
      if (op_ff == cxa_pkg::OP_MUL) begin
         fin_re = cxa_pkg::sat_mag(neg_re_ff, cxa_pkg::NW'(mag_re_ff >> cxa_pkg::FW));
         fin_im = cxa_pkg::sat_mag(neg_im_ff, cxa_pkg::NW'(mag_im_ff >> cxa_pkg::FW));
      end else begin
         fin_re = cxa_pkg::sat_mag(neg_re_ff, quo_re);
         fin_im = cxa_pkg::sat_mag(neg_im_ff, quo_im);
      end
   end

   assign add_re   = sat_add(acc_re_ff, br_ff, op_ff == cxa_pkg::OP_SUB);
   assign add_im   = sat_add(acc_im_ff, bi_ff, op_ff == cxa_pkg::OP_SUB);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequence one item through the serial units and hold the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         round_ff     <= '0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         // Raise the result beat on push, drop it once taken
         if (state_ff == S_PUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  br_ff    <= req_operand_real;
                  bi_ff    <= req_operand_imag;
                  round_ff <= '0;
                  state_ff <= S_ADD;
                  if (req_op == cxa_pkg::OP_MUL) begin
                     ma_a_ff      <= acc_re_ff;
                     ma_b_ff      <= req_operand_real;
                     mb_a_ff      <= acc_im_ff;
                     mb_b_ff      <= req_operand_imag;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL;
                  end else if (req_op == cxa_pkg::OP_DIV &&
                               (req_operand_real != '0 || req_operand_imag != '0)) begin
                     ma_a_ff      <= req_operand_real;
                     ma_b_ff      <= req_operand_real;
                     mb_a_ff      <= req_operand_imag;
                     mb_b_ff      <= req_operand_imag;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL;
                  end
               end
            end
            S_ADD: begin
               dbz_ff <= 1'b0;
               ovf_ff <= 1'b0;
               case (op_ff)
                  cxa_pkg::OP_LOAD: begin
                     res_re_ff <= br_ff;
                     res_im_ff <= bi_ff;
                     acc_re_ff <= br_ff;
                     acc_im_ff <= bi_ff;
                  end
                  cxa_pkg::OP_ADD, cxa_pkg::OP_SUB: begin
                     res_re_ff <= add_re.val;
                     res_im_ff <= add_im.val;
                     acc_re_ff <= add_re.val;
                     acc_im_ff <= add_im.val;
                     ovf_ff    <= add_re.ovf | add_im.ovf;
                  end
                  cxa_pkg::OP_DIV: begin
                     res_re_ff <= acc_re_ff;
                     res_im_ff <= acc_im_ff;
                     dbz_ff    <= 1'b1;
                  end
                  default: begin
                     res_re_ff <= acc_re_ff;
                     res_im_ff <= acc_im_ff;
                  end
               endcase
               state_ff <= S_PUSH;
            end
            S_MUL: begin
               if (mul_done_a && mul_done_b) begin
                  round_ff <= round_ff + 2'd1;
                  if (op_ff == cxa_pkg::OP_MUL) begin
                     if (round_ff == 2'd0) begin
                        sum_re_ff    <= prod_diff;
                        ma_a_ff      <= acc_re_ff;
                        ma_b_ff      <= bi_ff;
                        mb_a_ff      <= acc_im_ff;
                        mb_b_ff      <= br_ff;
                        mul_start_ff <= 1'b1;
                     end else begin
                        sum_im_ff <= prod_sum;
                        state_ff  <= S_MAG;
                     end
                  end else begin
                     case (round_ff)
                        2'd0: begin
                           den_ff       <= prod_sum[cxa_pkg::PW-1:0];
                           ma_a_ff      <= acc_re_ff;
                           ma_b_ff      <= br_ff;
                           mb_a_ff      <= acc_im_ff;
                           mb_b_ff      <= bi_ff;
                           mul_start_ff <= 1'b1;
                        end
                        2'd1: begin
                           sum_re_ff    <= prod_sum;
                           ma_a_ff      <= acc_im_ff;
                           ma_b_ff      <= br_ff;
                           mb_a_ff      <= acc_re_ff;
                           mb_b_ff      <= bi_ff;
                           mul_start_ff <= 1'b1;
                        end
                        default: begin
                           sum_im_ff <= prod_diff;
                           state_ff  <= S_MAG;
                        end
                     endcase
                  end
               end
            end
            S_MAG: begin
               neg_re_ff <= sum_re_ff[cxa_pkg::SW-1];
               neg_im_ff <= sum_im_ff[cxa_pkg::SW-1];
               mag_re_ff <= sum_re_ff[cxa_pkg::SW-1] ? cxa_pkg::PW'(-sum_re_ff)
                                                     : cxa_pkg::PW'(sum_re_ff);
               mag_im_ff <= sum_im_ff[cxa_pkg::SW-1] ? cxa_pkg::PW'(-sum_im_ff)
                                                     : cxa_pkg::PW'(sum_im_ff);
               if (op_ff == cxa_pkg::OP_MUL) begin
                  state_ff <= S_FIN;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done_re && div_done_im) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               res_re_ff <= fin_re.val;
               res_im_ff <= fin_im.val;
               acc_re_ff <= fin_re.val;
               acc_im_ff <= fin_im.val;
               dbz_ff    <= 1'b0;
               ovf_ff    <= fin_re.ovf | fin_im.ovf;
               state_ff  <= S_PUSH;
            end
            S_PUSH: begin
               if (out_free) begin
                  rsp_re_ff  <= res_re_ff;
                  rsp_im_ff  <= res_im_ff;
                  rsp_dbz_ff <= dbz_ff;
                  rsp_ovf_ff <= ovf_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_real    = rsp_re_ff;
   assign rsp_result_imag    = rsp_im_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

`default_nettype wire

[hw/rtl/cxa_checker.sv]
// Port-level checks for the complex accumulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cxa_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [cxa_pkg::DW-1:0]   rsp_result_real,
   input wire logic [cxa_pkg::DW-1:0]   rsp_result_imag,
   input wire logic                     rsp_divide_by_zero,
   input wire logic                     rsp_overflow
);

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_real) &&
                                  $stable(rsp_result_imag))
      else $error("stalled result beat changed");

   // A zero-divisor result never reports saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_divide_by_zero && rsp_overflow))
      else $error("divide by zero and overflow both set");

   // Reset leaves no result beat pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item in work at a time: accept drops ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

endmodule

bind complex_accumulator_alu cxa_checker u_cxa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_real    (rsp_result_real),
   .rsp_result_imag    (rsp_result_imag),
   .rsp_divide_by_zero (rsp_divide_by_zero),
   .rsp_overflow       (rsp_overflow)
);

`default_nettype wire
